@@ sv/gis_pkg.sv @@
// ----------------------------------------------------------------------------
// gis_pkg
// Shared types, codes and helpers of the GPS/IMU speed estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package gis_pkg;

	localparam logic [1:0] CMD_ACCEL = 2'd0;
	localparam logic [1:0] CMD_GPS   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] ST_VALID   = 2'd0;
	localparam logic [1:0] ST_NOFIX   = 2'd1;
	localparam logic [1:0] ST_CLOCK   = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	localparam logic [2:0] REG_MAX_SPEED    = 3'd0;
	localparam logic [2:0] REG_MIN_SATS     = 3'd1;
	localparam logic [2:0] REG_MAX_HDOP     = 3'd2;
	localparam logic [2:0] REG_GPS_TIMEOUT  = 3'd3;
	localparam logic [2:0] REG_MIN_INTERVAL = 3'd4;
	localparam logic [2:0] REG_GAIN         = 3'd5;
	localparam logic [2:0] REG_DEADBAND     = 3'd6;
	localparam logic [2:0] REG_BIAS         = 3'd7;

	localparam int SPD_W = 26;

	// ceil(2^36 / 1000): um/s to mm/s by multiply and shift, exact below 2^26
	localparam logic [26:0] MMS_RECIP = 27'd68719477;

	typedef struct packed {
		logic [15:0]        max_speed;
		logic [5:0]         min_sats;
		logic [15:0]        max_hdop;
		logic [15:0]        gps_timeout;
		logic [15:0]        min_interval;
		logic [16:0]        gain;
		logic [14:0]        deadband;
		logic signed [15:0] bias;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic dispatch;
		logic acc_mul;
		logic acc_add;
		logic med_step;
		logic med_mid;
		logic fix_first;
		logic diff;
		logic mul_lo;
		logic mul_hi;
		logic fix_upd;
		logic div;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       integrate;
		logic       gps_pass;
		logic       fix_started;
		logic       med_last;
		logic       out_free;
	} ctrl_stat_t;

	function automatic logic [SPD_W-1:0] clamp_speed(input logic signed [27:0] v,
			input logic [SPD_W-1:0] top);
		logic [SPD_W-1:0] r;
		if (v[27]) begin
			r = '0;
		end else if (v[26:0] > {1'b0, top}) begin
			r = top;
		end else begin
			r = v[SPD_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/gis_ctrl.sv @@
// ----------------------------------------------------------------------------
// gis_ctrl
// Sequencer of the estimator: steps the datapath through one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module gis_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  gis_pkg::ctrl_stat_t     stat,
	output gis_pkg::ctrl_cmd_t      ctl
);

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_DISP     = 13'b0000000000010,
		S_ACC_MUL  = 13'b0000000000100,
		S_ACC_ADD  = 13'b0000000001000,
		S_MED      = 13'b0000000010000,
		S_MID      = 13'b0000000100000,
		S_FIRST    = 13'b0000001000000,
		S_DIFF     = 13'b0000010000000,
		S_MLO      = 13'b0000100000000,
		S_MHI      = 13'b0001000000000,
		S_UPD      = 13'b0010000000000,
		S_DIV      = 13'b0100000000000,
		S_OUT      = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				ctl.dispatch = 1'b1;
				state_d = S_DIV;
				if (stat.cmd == gis_pkg::CMD_ACCEL && stat.integrate) begin
					state_d = S_ACC_MUL;
				end else if (stat.cmd == gis_pkg::CMD_GPS && stat.gps_pass) begin
					state_d = S_MED;
				end
			end
			S_ACC_MUL: begin
				ctl.acc_mul = 1'b1;
				state_d = S_ACC_ADD;
			end
			S_ACC_ADD: begin
				ctl.acc_add = 1'b1;
				state_d = S_DIV;
			end
			S_MED: begin
				ctl.med_step = 1'b1;
				if (stat.med_last) begin
					state_d = S_MID;
				end
			end
			S_MID: begin
				ctl.med_mid = 1'b1;
				state_d = stat.fix_started ? S_DIFF : S_FIRST;
			end
			S_FIRST: begin
				ctl.fix_first = 1'b1;
				state_d = S_DIV;
			end
			S_DIFF: begin
				ctl.diff = 1'b1;
				state_d = S_MLO;
			end
			S_MLO: begin
				ctl.mul_lo = 1'b1;
				state_d = S_MHI;
			end
			S_MHI: begin
				ctl.mul_hi = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				ctl.fix_upd = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				ctl.div = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> state_q == S_DISP)
		else $error("load did not lead to dispatch");
	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !stat.out_free) |=> state_q == S_OUT)
		else $error("result dropped while output busy");

endmodule

`default_nettype wire

@@ sv/gis_dp.sv @@
// ----------------------------------------------------------------------------
// gis_dp
// Datapath: estimator state, median window, multiply steps, scaling, output.
// ----------------------------------------------------------------------------
`default_nettype none

module gis_dp #(
	parameter int WINDOW_LEN = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  gis_pkg::cfg_t           cfg,
	input  gis_pkg::ctrl_cmd_t      ctl,
	output gis_pkg::ctrl_stat_t     stat,
	input  wire logic [1:0]         cmd,
	input  wire logic [31:0]        time_ms,
	input  wire logic signed [15:0] accel,
	input  wire logic [15:0]        gps_speed,
	input  wire logic [5:0]         sat_count,
	input  wire logic [15:0]        fix_hdop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    fix_accepted,
	output logic                    est_valid,
	output logic [15:0]             speed,
	output logic [31:0]             age_ms,
	output logic [5:0]              last_sats,
	output logic [15:0]             last_hdop,
	output logic [1:0]              status
);

	localparam int CW = $clog2(WINDOW_LEN + 1);
	localparam int IW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int SW = gis_pkg::SPD_W;

	logic [1:0]         cmd_q;
	logic [31:0]        now_q;
	logic signed [15:0] accel_q;
	logic [15:0]        gps_q;
	logic [5:0]         sats_q;
	logic [15:0]        hdop_q;
	logic [SW-1:0]      top_q;

	logic [SW-1:0]      spd_q;
	logic [31:0]        lacc_q;
	logic [31:0]        lfix_q;
	logic [5:0]         hsats_q;
	logic [15:0]        hhdop_q;
	logic               acc_started_q;
	logic               fix_started_q;
	logic [15:0]        win_q [WINDOW_LEN];
	logic [CW-1:0]      fill_q;
	logic [IW-1:0]      head_q;

	logic signed [16:0] a_q;
	logic [8:0]         dt_q;
	logic signed [26:0] prod_q;
	logic [IW-1:0]      med_i_q;
	logic [15:0]        lo_q;
	logic [15:0]        hi_q;
	logic [SW-1:0]      med_q;
	logic [SW-1:0]      ad_q;
	logic               neg_q;
	logic [42:0]        p_q;
	logic [15:0]        quo_q;
	logic               acc_q;
	logic               out_valid_q;

	logic [32:0]        dt33;
	logic               dt_ok;
	logic signed [16:0] a17;
	logic [16:0]        abs17;
	logic [32:0]        fdt33;
	logic               too_soon;
	logic               pass;
	logic [15:0]        cand;
	logic [CW-1:0]      lt_cnt;
	logic [CW-1:0]      le_cnt;
	logic [CW-1:0]      k_lo;
	logic [CW-1:0]      k_hi;
	logic signed [27:0] d28;
	logic [16:0]        gain_eff;
	logic [29:0]        pm_lo;
	logic [29:0]        pm_hi;
	logic [43:0]        rnd;
	logic [SW-1:0]      stp;
	logic signed [27:0] upd_sum;
	logic [52:0]        qprod;
	logic [32:0]        age33;
	logic [CW-1:0]      fill_nx;

	assign dt33  = {1'b0, now_q} - {1'b0, lacc_q};
	assign dt_ok = !dt33[32] && (dt33[31:0] != 32'd0) && (dt33[31:0] <= 32'd500);
	assign a17   = {accel_q[15], accel_q} - {cfg.bias[15], cfg.bias};
	assign abs17 = a17[16] ? 17'(-a17) : 17'(a17);

	assign fdt33    = {1'b0, now_q} - {1'b0, lfix_q};
	assign too_soon = fix_started_q && (fdt33[32] || (fdt33[31:0] < {16'd0, cfg.min_interval}));
	assign pass     = (gps_q <= cfg.max_speed) && (sats_q >= cfg.min_sats) &&
		(hdop_q != 16'd0) && (hdop_q <= cfg.max_hdop) && !too_soon;

	assign cand = win_q[med_i_q];
	assign k_lo = (fill_q - CW'(1)) >> 1;
	assign k_hi = fill_q >> 1;

	always_comb begin
		lt_cnt = '0;
		le_cnt = '0;
		for (int j = 0; j < WINDOW_LEN; j++) begin
			if (CW'(j) < fill_q) begin
				lt_cnt = lt_cnt + CW'(win_q[j] < cand);
				le_cnt = le_cnt + CW'(win_q[j] <= cand);
			end
		end
	end

	assign d28      = $signed({2'b00, med_q}) - $signed({2'b00, spd_q});
	assign gain_eff = (cfg.gain > 17'd65536) ? 17'd65536 : cfg.gain;
	assign pm_lo    = {17'd0, ad_q[12:0]} * {13'd0, gain_eff};
	assign pm_hi    = {17'd0, ad_q[SW-1:13]} * {13'd0, gain_eff};
	assign rnd      = {1'b0, p_q} + 44'd32768;
	assign stp      = rnd[SW+15:16];
	assign upd_sum  = neg_q ? $signed({2'b00, spd_q}) - $signed({2'b00, stp})
		: $signed({2'b00, spd_q}) + $signed({2'b00, stp});
	assign qprod    = {27'd0, spd_q} * {26'd0, gis_pkg::MMS_RECIP};
	assign age33    = {1'b0, now_q} - {1'b0, lfix_q};
	assign fill_nx  = (fill_q < CW'(WINDOW_LEN)) ? fill_q + CW'(1) : fill_q;

	// item registers and work registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd;
			now_q   <= time_ms;
			accel_q <= accel;
			gps_q   <= gps_speed;
			sats_q  <= sat_count;
			hdop_q  <= fix_hdop;
			top_q   <= {10'd0, cfg.max_speed} * 26'd1000;
		end
		if (ctl.dispatch) begin
			a_q     <= (abs17 < {2'b00, cfg.deadband}) ? 17'sd0 : a17;
			dt_q    <= dt33[8:0];
			med_i_q <= '0;
		end
		if (ctl.acc_mul) begin
			prod_q <= 27'(a_q) * 27'($signed({1'b0, dt_q}));
		end
		if (ctl.med_step) begin
			if (lt_cnt <= k_lo && k_lo < le_cnt) begin
				lo_q <= cand;
			end
			if (lt_cnt <= k_hi && k_hi < le_cnt) begin
				hi_q <= cand;
			end
			med_i_q <= med_i_q + IW'(1);
		end
		if (ctl.med_mid) begin
			med_q <= ({10'd0, lo_q} + {10'd0, hi_q}) * 26'd500;
		end
		if (ctl.diff) begin
			neg_q <= d28[27];
			ad_q  <= d28[27] ? SW'(-d28) : SW'(d28);
		end
		if (ctl.mul_lo) begin
			p_q <= {13'd0, pm_lo};
		end
		if (ctl.mul_hi) begin
			p_q <= p_q + {pm_hi, 13'd0};
		end
		if (ctl.div) begin
			quo_q <= qprod[51:36];
		end
	end

	// median window storage
	always_ff @(posedge clk) begin
		if (ctl.dispatch && cmd_q == gis_pkg::CMD_GPS && pass) begin
			win_q[head_q] <= gps_q;
		end
	end

	// estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_q         <= '0;
			lacc_q        <= '0;
			lfix_q        <= '0;
			hsats_q       <= '0;
			hhdop_q       <= '0;
			acc_started_q <= 1'b0;
			fix_started_q <= 1'b0;
			fill_q        <= '0;
			head_q        <= '0;
			acc_q         <= 1'b0;
		end else begin
			if (ctl.load) begin
				acc_q <= 1'b0;
			end
			if (ctl.dispatch) begin
				case (cmd_q)
					gis_pkg::CMD_ACCEL: begin
						acc_started_q <= 1'b1;
						lacc_q        <= now_q;
					end
					gis_pkg::CMD_GPS: begin
						if (pass) begin
							acc_q  <= 1'b1;
							fill_q <= fill_nx;
							head_q <= (head_q == IW'(WINDOW_LEN - 1)) ? '0 : head_q + IW'(1);
						end
					end
					gis_pkg::CMD_CLEAR: begin
						spd_q         <= '0;
						lacc_q        <= '0;
						lfix_q        <= '0;
						hsats_q       <= '0;
						hhdop_q       <= '0;
						acc_started_q <= 1'b0;
						fix_started_q <= 1'b0;
						fill_q        <= '0;
						head_q        <= '0;
					end
					default: begin
					end
				endcase
			end
			if (ctl.acc_add) begin
				spd_q <= gis_pkg::clamp_speed($signed({2'b00, spd_q}) + 28'(prod_q), top_q);
			end
			if (ctl.fix_first || ctl.fix_upd) begin
				spd_q <= gis_pkg::clamp_speed(ctl.fix_first ? $signed({2'b00, med_q}) : upd_sum,
					top_q);
				fix_started_q <= 1'b1;
				lfix_q        <= now_q;
				hsats_q       <= sats_q;
				hhdop_q       <= hdop_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			fix_accepted <= acc_q;
			est_valid    <= 1'b0;
			speed        <= '0;
			age_ms       <= '0;
			last_sats    <= '0;
			last_hdop    <= '0;
			if (!fix_started_q) begin
				status <= gis_pkg::ST_NOFIX;
			end else begin
				last_sats <= hsats_q;
				last_hdop <= hhdop_q;
				if (age33[32]) begin
					status <= gis_pkg::ST_CLOCK;
				end else begin
					age_ms <= age33[31:0];
					if (age33[31:0] > {16'd0, cfg.gps_timeout}) begin
						status <= gis_pkg::ST_TIMEOUT;
					end else begin
						status    <= gis_pkg::ST_VALID;
						est_valid <= 1'b1;
						speed     <= quo_q;
					end
				end
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat.cmd         = cmd_q;
		stat.integrate   = acc_started_q && dt_ok && fix_started_q;
		stat.gps_pass    = pass;
		stat.fix_started = fix_started_q;
		stat.med_last    = (CW'(med_i_q) == fill_q - CW'(1));
		stat.out_free    = !out_valid_q || out_ready;
	end

	a_fill: assert property (@(posedge clk) disable iff (!arst_n) fill_q <= CW'(WINDOW_LEN))
		else $error("window fill beyond length");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transfer");
	a_valid_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && est_valid) |-> (status == gis_pkg::ST_VALID && fix_started_q == 1'b1
		|| status == gis_pkg::ST_VALID))
		else $error("valid estimate with non-valid status");

endmodule

`default_nettype wire

@@ sv/gps_imu_speed_estimator_unit.sv @@
// ----------------------------------------------------------------------------
// gps_imu_speed_estimator_unit
// GPS/IMU forward speed estimator with median-filtered GPS correction.
// ----------------------------------------------------------------------------
// one item at a time; in_ready is high only while the sequencer idles
// steps: load, dispatch, divide, output; an integrated accel sample adds multiply and add;
//   a fix adds median steps (1 step per entry) and midpoint, then first load or, for a later
//   fix, difference, low and high multiply and update; output waits while a result is untaken
// reset clears all estimator state and loads register defaults; no clearing pass
`default_nettype none

module gps_imu_speed_estimator_unit #(
	parameter int WINDOW_LEN = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [16:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic [31:0]        time_ms,
	input  wire logic signed [15:0] accel,
	input  wire logic [15:0]        gps_speed,
	input  wire logic [5:0]         sat_count,
	input  wire logic [15:0]        fix_hdop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    fix_accepted,
	output logic                    est_valid,
	output logic [15:0]             speed,
	output logic [31:0]             age_ms,
	output logic [5:0]              last_sats,
	output logic [15:0]             last_hdop,
	output logic [1:0]              status
);

	gis_pkg::cfg_t       cfg_q;
	gis_pkg::ctrl_cmd_t  ctl;
	gis_pkg::ctrl_stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed    <= 16'd30000;
			cfg_q.min_sats     <= 6'd4;
			cfg_q.max_hdop     <= 16'd250;
			cfg_q.gps_timeout  <= 16'd1000;
			cfg_q.min_interval <= 16'd0;
			cfg_q.gain         <= 17'd16384;
			cfg_q.deadband     <= 15'd0;
			cfg_q.bias         <= 16'sd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				gis_pkg::REG_MAX_SPEED:    cfg_q.max_speed    <= cfg_data[15:0];
				gis_pkg::REG_MIN_SATS:     cfg_q.min_sats     <= cfg_data[5:0];
				gis_pkg::REG_MAX_HDOP:     cfg_q.max_hdop     <= cfg_data[15:0];
				gis_pkg::REG_GPS_TIMEOUT:  cfg_q.gps_timeout  <= cfg_data[15:0];
				gis_pkg::REG_MIN_INTERVAL: cfg_q.min_interval <= cfg_data[15:0];
				gis_pkg::REG_GAIN:         cfg_q.gain         <= cfg_data;
				gis_pkg::REG_DEADBAND:     cfg_q.deadband     <= cfg_data[14:0];
				gis_pkg::REG_BIAS:         cfg_q.bias         <= $signed(cfg_data[15:0]);
				default: begin
				end
			endcase
		end
	end

	gis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	gis_dp #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.ctl          (ctl),
		.stat         (stat),
		.cmd          (cmd),
		.time_ms      (time_ms),
		.accel        (accel),
		.gps_speed    (gps_speed),
		.sat_count    (sat_count),
		.fix_hdop     (fix_hdop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fix_accepted (fix_accepted),
		.est_valid    (est_valid),
		.speed        (speed),
		.age_ms       (age_ms),
		.last_sats    (last_sats),
		.last_hdop    (last_hdop),
		.status       (status)
	);

endmodule

`default_nettype wire
